// ===== rtl/sobs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sobs_pkg
// Types and constants shared by the shifter operand pipeline.
// ----------------------------------------------------------------------------
package sobs_pkg;

   localparam int unsigned DATA_W  = 32;
   localparam int unsigned FIELD_W = 12;
   localparam int unsigned AMT_W   = 5;
   localparam int unsigned RSB_W   = 8;

   localparam logic [3:0] PC_INDEX = 4'hF;

   typedef enum logic [1:0] {
      SHIFT_LSL = 2'd0,
      SHIFT_LSR = 2'd1,
      SHIFT_ASR = 2'd2,
      SHIFT_ROR = 2'd3
   } shift_kind_type;

   typedef enum logic [2:0] {
      CARRY_FROM_IN  = 3'b001,
      CARRY_FROM_BIT = 3'b010,
      CARRY_ZERO     = 3'b100
   } carry_mode_type;

   // decode stage -> rotate stage
   typedef struct packed {
      logic [DATA_W-1:0] src;
      logic [AMT_W-1:0]  rot;
      logic [AMT_W-1:0]  shamt;
      logic              clear_all;
      logic              left;
      logic              fill;
      carry_mode_type    carry_mode;
      logic [AMT_W-1:0]  carry_idx;
      logic              carry_in;
   } decode_type;

   // rotate stage -> merge stage
   typedef struct packed {
      logic [DATA_W-1:0] rotated;
      logic [DATA_W-1:0] keep_mask;
      logic              fill;
      logic              carry;
   } rotate_type;

endpackage
`default_nettype wire

// ===== rtl/sobs_channels.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sobs_channels
// Valid/ready channel interfaces for requests and responses.
// ----------------------------------------------------------------------------
interface sobs_req_if;
   logic                         valid;
   logic                         ready;
   logic [sobs_pkg::FIELD_W-1:0] operand_field;
   logic                         is_immediate;
   logic [sobs_pkg::DATA_W-1:0]  rm_value;
   logic [sobs_pkg::RSB_W-1:0]   shift_register_byte;
   logic                         carry_in;

   modport source (
      output valid, operand_field, is_immediate, rm_value, shift_register_byte, carry_in,
      input  ready
   );
   modport sink (
      input  valid, operand_field, is_immediate, rm_value, shift_register_byte, carry_in,
      output ready
   );
endinterface

interface sobs_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [sobs_pkg::DATA_W-1:0] shifter_value;
   logic                        carry_out;

   modport source (
      output valid, shifter_value, carry_out,
      input  ready
   );
   modport sink (
      input  valid, shifter_value, carry_out,
      output ready
   );
endinterface
`default_nettype wire

// ===== rtl/sobs_decode_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sobs_decode_stage
// Decodes the operand field into a rotate amount, mask controls, fill bit and carry select.
// ----------------------------------------------------------------------------
module sobs_decode_stage (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          in_valid,
   output logic                         in_ready,
   input  wire [sobs_pkg::FIELD_W-1:0]  operand_field,
   input  wire                          is_immediate,
   input  wire [sobs_pkg::DATA_W-1:0]   rm_value,
   input  wire [sobs_pkg::RSB_W-1:0]    shift_register_byte,
   input  wire                          carry_in,
   output logic                         out_valid,
   input  wire                          out_ready,
   output sobs_pkg::decode_type         out_data
);

   logic                        valid_ff;
   logic                        valid_in;
   sobs_pkg::decode_type        data_ff;
   sobs_pkg::decode_type        data_in;

   sobs_pkg::shift_kind_type    kind;
   logic                        by_reg;
   logic [sobs_pkg::AMT_W-1:0]  imm_sh;
   logic [3:0]                  rot4;
   logic [sobs_pkg::RSB_W-1:0]  amt;
   logic [sobs_pkg::AMT_W-1:0]  amt5;
   logic                        amt_small;
   logic                        amt_32;
   logic [sobs_pkg::DATA_W-1:0] src;

   always_comb begin
      kind   = sobs_pkg::shift_kind_type'(operand_field[6:5]);
      by_reg = operand_field[4];
      imm_sh = operand_field[11:7];
      rot4   = operand_field[11:8];

      if (by_reg && operand_field[3:0] == sobs_pkg::PC_INDEX) begin
         src = rm_value + 32'd4;
      end else begin
         src = rm_value;
      end

      if (by_reg) begin
         amt = shift_register_byte;
      end else if (imm_sh == 5'd0 &&
                   (kind == sobs_pkg::SHIFT_LSR || kind == sobs_pkg::SHIFT_ASR)) begin
         amt = 8'd32;
      end else begin
         amt = {3'd0, imm_sh};
      end
      amt5      = amt[4:0];
      amt_small = (amt[7:5] == 3'd0);
      amt_32    = (amt == 8'd32);

      data_in.src        = src;
      data_in.rot        = 5'd0;
      data_in.shamt      = 5'd0;
      data_in.clear_all  = 1'b0;
      data_in.left       = 1'b0;
      data_in.fill       = 1'b0;
      data_in.carry_mode = sobs_pkg::CARRY_FROM_IN;
      data_in.carry_idx  = 5'd0;
      data_in.carry_in   = carry_in;

      if (is_immediate) begin
         data_in.src = {24'd0, operand_field[7:0]};
         data_in.rot = {rot4, 1'b0};
         if (rot4 != 4'd0) begin
            data_in.carry_mode = sobs_pkg::CARRY_FROM_BIT;
            data_in.carry_idx  = {rot4, 1'b0} - 5'd1;
         end
      end else if (!by_reg && imm_sh == 5'd0 && kind == sobs_pkg::SHIFT_ROR) begin
         // rotate right extended
         data_in.rot        = 5'd1;
         data_in.shamt      = 5'd1;
         data_in.fill       = carry_in;
         data_in.carry_mode = sobs_pkg::CARRY_FROM_BIT;
         data_in.carry_idx  = 5'd0;
      end else if (amt != 8'd0) begin
         case (kind)
            sobs_pkg::SHIFT_LSL: begin
               data_in.left = 1'b1;
               if (amt_small) begin
                  data_in.rot        = 5'd0 - amt5;
                  data_in.shamt      = amt5;
                  data_in.carry_mode = sobs_pkg::CARRY_FROM_BIT;
                  data_in.carry_idx  = 5'd0 - amt5;
               end else begin
                  data_in.clear_all  = 1'b1;
                  data_in.carry_mode = amt_32 ? sobs_pkg::CARRY_FROM_BIT
                                              : sobs_pkg::CARRY_ZERO;
                  data_in.carry_idx  = 5'd0;
               end
            end
            sobs_pkg::SHIFT_LSR, sobs_pkg::SHIFT_ASR: begin
               data_in.fill = (kind == sobs_pkg::SHIFT_ASR) ? src[31] : 1'b0;
               if (amt_small) begin
                  data_in.rot        = amt5;
                  data_in.shamt      = amt5;
                  data_in.carry_mode = sobs_pkg::CARRY_FROM_BIT;
                  data_in.carry_idx  = amt5 - 5'd1;
               end else begin
                  data_in.clear_all  = 1'b1;
                  data_in.carry_mode = (amt_32 || kind == sobs_pkg::SHIFT_ASR)
                                       ? sobs_pkg::CARRY_FROM_BIT : sobs_pkg::CARRY_ZERO;
                  data_in.carry_idx  = 5'd31;
               end
            end
            default: begin
               data_in.rot        = amt5;
               data_in.carry_mode = sobs_pkg::CARRY_FROM_BIT;
               data_in.carry_idx  = (amt5 == 5'd0) ? 5'd31 : amt5 - 5'd1;
            end
         endcase
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

// ===== rtl/sobs_rotate_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sobs_rotate_stage
// Barrel rotate, keep-mask generation and carry bit selection.
// ----------------------------------------------------------------------------
module sobs_rotate_stage (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        in_valid,
   output logic                       in_ready,
   input  wire sobs_pkg::decode_type  in_data,
   output logic                       out_valid,
   input  wire                        out_ready,
   output sobs_pkg::rotate_type       out_data
);

   logic                            valid_ff;
   logic                            valid_in;
   sobs_pkg::rotate_type            data_ff;
   sobs_pkg::rotate_type            data_in;
   logic [2*sobs_pkg::DATA_W-1:0]   doubled;
   logic [2*sobs_pkg::DATA_W-1:0]   shifted;
   logic [sobs_pkg::DATA_W-1:0]     ones;

   always_comb begin
      ones    = '1;
      doubled = {in_data.src, in_data.src};
      shifted = doubled >> in_data.rot;

      data_in.rotated = shifted[sobs_pkg::DATA_W-1:0];
      data_in.fill    = in_data.fill;

      if (in_data.clear_all) begin
         data_in.keep_mask = '0;
      end else if (in_data.left) begin
         data_in.keep_mask = ones << in_data.shamt;
      end else begin
         data_in.keep_mask = ones >> in_data.shamt;
      end

      case (in_data.carry_mode)
         sobs_pkg::CARRY_FROM_BIT: data_in.carry = in_data.src[in_data.carry_idx];
         sobs_pkg::CARRY_ZERO:     data_in.carry = 1'b0;
         default:                  data_in.carry = in_data.carry_in;
      endcase
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

// ===== rtl/sobs_merge_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sobs_merge_stage
// Applies the keep mask and fill bit; holds the response register.
// ----------------------------------------------------------------------------
module sobs_merge_stage (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          in_valid,
   output logic                         in_ready,
   input  wire sobs_pkg::rotate_type    in_data,
   output logic                         out_valid,
   input  wire                          out_ready,
   output logic [sobs_pkg::DATA_W-1:0]  out_value,
   output logic                         out_carry
);

   logic                        valid_ff;
   logic                        valid_in;
   logic [sobs_pkg::DATA_W-1:0] value_ff;
   logic [sobs_pkg::DATA_W-1:0] value_in;
   logic                        carry_ff;

   assign value_in = (in_data.rotated & in_data.keep_mask) |
                     (~in_data.keep_mask & {sobs_pkg::DATA_W{in_data.fill}});

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         value_ff <= value_in;
         carry_ff <= in_data.carry;
      end
   end

   assign out_valid = valid_ff;
   assign out_value = value_ff;
   assign out_carry = carry_ff;

endmodule
`default_nettype wire

// ===== rtl/shifter_operand_barrel_shifter_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shifter_operand_barrel_shifter_core
// Second-operand generator with shifter carry-out for data-processing ops.
//
// req_channel: one transaction per instruction carries the 12-bit operand
//   field, the immediate flag, Rm, the low byte of Rs and the carry flag.
// rsp_channel: one transaction per request with the shifted or rotated
//   operand and the shifter carry-out, in request order.
// Pipeline: an accepted request is registered in the decode, rotate and merge
//   register stages in turn before its response is valid.
// Throughput: one transaction per cycle; a new request is taken every cycle
//   while the response side keeps up.
// Reset (synchronous, active high) empties all stages; no responses are
//   pending afterwards.
// Stall: when rsp_channel.ready is low, stages fill behind the response
//   register and req_channel.ready drops once all three stages hold data;
//   nothing is dropped or duplicated.
// ----------------------------------------------------------------------------
module shifter_operand_barrel_shifter_core (
   input  wire        clock,
   input  wire        reset,
   sobs_req_if.sink   req_channel,
   sobs_rsp_if.source rsp_channel
);

   logic                 dec_valid;
   logic                 dec_ready;
   sobs_pkg::decode_type dec_data;
   logic                 rot_valid;
   logic                 rot_ready;
   sobs_pkg::rotate_type rot_data;

   sobs_decode_stage u_decode (
      .clock               (clock),
      .reset               (reset),
      .in_valid            (req_channel.valid),
      .in_ready            (req_channel.ready),
      .operand_field       (req_channel.operand_field),
      .is_immediate        (req_channel.is_immediate),
      .rm_value            (req_channel.rm_value),
      .shift_register_byte (req_channel.shift_register_byte),
      .carry_in            (req_channel.carry_in),
      .out_valid           (dec_valid),
      .out_ready           (dec_ready),
      .out_data            (dec_data)
   );

   sobs_rotate_stage u_rotate (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_data   (dec_data),
      .out_valid (rot_valid),
      .out_ready (rot_ready),
      .out_data  (rot_data)
   );

   sobs_merge_stage u_merge (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rot_valid),
      .in_ready  (rot_ready),
      .in_data   (rot_data),
      .out_valid (rsp_channel.valid),
      .out_ready (rsp_channel.ready),
      .out_value (rsp_channel.shifter_value),
      .out_carry (rsp_channel.carry_out)
   );

endmodule
`default_nettype wire

// ===== tb/tb_shifter_operand_barrel_shifter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shifter_operand_barrel_shifter_core
// Drives instruction operand transactions into the shifter operand core and
// checks each response, in order, against a behavioral operand predictor.
// A directed set of special cases is followed by random traffic. The run
// cycles through four idle/stall phases and includes one long response
// hold-off that backs the pipeline up into the request side.
// ----------------------------------------------------------------------------
module tb_shifter_operand_barrel_shifter_core;

   localparam int RANDOM_INSTRS = 1450;
   localparam int PHASE_LEN     = 180;
   localparam int MAX_REPORTS   = 10;

   typedef struct packed {
      logic [sobs_pkg::FIELD_W-1:0] operand_field;
      logic                         is_immediate;
      logic [sobs_pkg::DATA_W-1:0]  rm_value;
      logic [sobs_pkg::RSB_W-1:0]   shift_register_byte;
      logic                         carry_in;
   } operand_req_type;

   typedef struct packed {
      logic [sobs_pkg::DATA_W-1:0] value;
      logic                        carry;
   } operand_rsp_type;

   logic clock;
   logic reset;
   logic rsp_hold;

   operand_req_type instr_queue[$];
   operand_rsp_type expected_operands[$];
   operand_req_type offered_instr;
   int              accepted_instrs;
   int              mismatch_count;

   sobs_req_if req_if ();
   sobs_rsp_if rsp_if ();

   shifter_operand_barrel_shifter_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_channel (req_if),
      .rsp_channel (rsp_if)
   );

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------
   function automatic operand_rsp_type barrel_shift(logic [sobs_pkg::DATA_W-1:0] src,
                                                    sobs_pkg::shift_kind_type kind,
                                                    int unsigned amt, logic cin);
      operand_rsp_type r;
      int unsigned     rot;
      r.value = src;
      r.carry = cin;
      if (amt == 0) return r;
      case (kind)
         sobs_pkg::SHIFT_LSL: begin
            if (amt < 32) begin
               r.value = src << amt;
               r.carry = src[32 - amt];
            end else begin
               r.value = '0;
               r.carry = (amt == 32) ? src[0] : 1'b0;
            end
         end
         sobs_pkg::SHIFT_LSR: begin
            if (amt < 32) begin
               r.value = src >> amt;
               r.carry = src[amt - 1];
            end else begin
               r.value = '0;
               r.carry = (amt == 32) ? src[31] : 1'b0;
            end
         end
         sobs_pkg::SHIFT_ASR: begin
            if (amt < 32) begin
               r.value = $signed(src) >>> amt;
               r.carry = src[amt - 1];
            end else begin
               r.value = {sobs_pkg::DATA_W{src[31]}};
               r.carry = src[31];
            end
         end
         default: begin
            rot = amt % 32;
            if (rot == 0) begin
               r.value = src;
               r.carry = src[31];
            end else begin
               r.value = (src >> rot) | (src << (32 - rot));
               r.carry = src[rot - 1];
            end
         end
      endcase
      return r;
   endfunction

   function automatic operand_rsp_type compute_operand(operand_req_type instr);
      operand_rsp_type             r;
      sobs_pkg::shift_kind_type    kind;
      logic [4:0]                  shamt;
      logic [sobs_pkg::DATA_W-1:0] src;
      logic [11:0]                 f;
      f     = instr.operand_field;
      kind  = sobs_pkg::shift_kind_type'(f[6:5]);
      shamt = f[11:7];
      src   = instr.rm_value;
      if (instr.is_immediate) begin
         // rotate by zero keeps carry_in; otherwise carry is result bit 31
         r = barrel_shift({24'h0, f[7:0]}, sobs_pkg::SHIFT_ROR, 2 * f[11:8],
                          instr.carry_in);
      end else if (f[4]) begin
         if (f[3:0] == sobs_pkg::PC_INDEX) src = src + 32'd4;
         r = barrel_shift(src, kind, instr.shift_register_byte, instr.carry_in);
      end else if (shamt == 0 && kind == sobs_pkg::SHIFT_ROR) begin
         r.value = {instr.carry_in, src[31:1]};
         r.carry = src[0];
      end else if (shamt == 0 &&
                   (kind == sobs_pkg::SHIFT_LSR || kind == sobs_pkg::SHIFT_ASR)) begin
         r = barrel_shift(src, kind, 32, instr.carry_in);
      end else begin
         r = barrel_shift(src, kind, shamt, instr.carry_in);
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Transaction builders
   // ---------------------------------------------------------------------
   function automatic operand_req_type imm_instr(logic [3:0] rot, logic [7:0] imm8,
                                                 logic cin);
      operand_req_type t;
      t.operand_field       = {rot, imm8};
      t.is_immediate        = 1'b1;
      t.rm_value            = $urandom;
      t.shift_register_byte = 8'($urandom_range(255));
      t.carry_in            = cin;
      return t;
   endfunction

   function automatic operand_req_type shimm_instr(logic [4:0] shamt,
                                                   sobs_pkg::shift_kind_type kind,
                                                   logic [31:0] rm, logic cin);
      operand_req_type t;
      t.operand_field       = {shamt, kind, 1'b0, 4'($urandom_range(15))};
      t.is_immediate        = 1'b0;
      t.rm_value            = rm;
      t.shift_register_byte = 8'($urandom_range(255));
      t.carry_in            = cin;
      return t;
   endfunction

   function automatic operand_req_type shreg_instr(sobs_pkg::shift_kind_type kind,
                                                   logic [3:0] rm_idx,
                                                   logic [31:0] rm, logic [7:0] rsb,
                                                   logic cin);
      operand_req_type t;
      t.operand_field       = {4'($urandom_range(15)), 1'b0, kind, 1'b1, rm_idx};
      t.is_immediate        = 1'b0;
      t.rm_value            = rm;
      t.shift_register_byte = rsb;
      t.carry_in            = cin;
      return t;
   endfunction

   function automatic int idle_phase();
      return (accepted_instrs / PHASE_LEN) % 4;
   endfunction

   function automatic bit roll(int pct);
      return $urandom_range(99) < pct;
   endfunction

   // ---------------------------------------------------------------------
   // Clock and reset
   // ---------------------------------------------------------------------
   initial begin
      clock                             = 1'b0;
      reset                             = 1'b1;
      rsp_hold                          = 1'b0;
      req_if.valid                      = 1'b0;
      req_if.operand_field              = '0;
      req_if.is_immediate               = 1'b0;
      req_if.rm_value                   = '0;
      req_if.shift_register_byte        = '0;
      req_if.carry_in                   = 1'b0;
      rsp_if.ready                      = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------------
   // Request driver
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      int pct;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            expected_operands.push_back(compute_operand(offered_instr));
            accepted_instrs++;
         end
         if (!req_if.valid || req_if.ready) begin
            pct = (idle_phase() == 1) ? 57 : (idle_phase() == 3) ? 33 : 0;
            if (instr_queue.size() > 0 && !roll(pct)) begin
               offered_instr                = instr_queue.pop_front();
               req_if.valid               <= 1'b1;
               req_if.operand_field       <= offered_instr.operand_field;
               req_if.is_immediate        <= offered_instr.is_immediate;
               req_if.rm_value            <= offered_instr.rm_value;
               req_if.shift_register_byte <= offered_instr.shift_register_byte;
               req_if.carry_in            <= offered_instr.carry_in;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response ready and monitor
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      int pct;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         pct = (idle_phase() == 2) ? 57 : (idle_phase() == 3) ? 33 : 0;
         rsp_if.ready <= !rsp_hold && !roll(pct);
      end
   end

   always @(posedge clock) begin
      operand_rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_operands.size() == 0) begin
            if (mismatch_count < MAX_REPORTS)
               $display("ERROR: unexpected transaction value=%08h carry=%0b",
                        rsp_if.shifter_value, rsp_if.carry_out);
            mismatch_count++;
         end else begin
            want = expected_operands.pop_front();
            if (rsp_if.shifter_value !== want.value || rsp_if.carry_out !== want.carry) begin
               if (mismatch_count < MAX_REPORTS)
                  $display("ERROR: value exp=%08h got=%08h, carry exp=%0b got=%0b",
                           want.value, rsp_if.shifter_value, want.carry,
                           rsp_if.carry_out);
               mismatch_count++;
            end
         end
      end
   end

   // long response hold-off so the pipeline fills and stalls requests
   initial begin
      while (reset || accepted_instrs < 60) @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (80) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Stimulus and end of test
   // ---------------------------------------------------------------------
   initial begin
      operand_req_type item;
      accepted_instrs = 0;
      mismatch_count  = 0;

      instr_queue.push_back(imm_instr(4'h0, 8'hFF, 1'b1));
      instr_queue.push_back(imm_instr(4'h0, 8'h80, 1'b0));
      instr_queue.push_back(imm_instr(4'h1, 8'hFF, 1'b0));
      instr_queue.push_back(imm_instr(4'hF, 8'h81, 1'b1));
      instr_queue.push_back(imm_instr(4'h4, 8'h7F, 1'b1));
      instr_queue.push_back(shimm_instr(5'd0, sobs_pkg::SHIFT_LSL, 32'h8000_0001, 1'b1));
      instr_queue.push_back(shimm_instr(5'd31, sobs_pkg::SHIFT_LSL, 32'h0000_0001, 1'b0));
      instr_queue.push_back(shimm_instr(5'd1, sobs_pkg::SHIFT_LSR, 32'hFFFF_FFFF, 1'b0));
      instr_queue.push_back(shimm_instr(5'd0, sobs_pkg::SHIFT_LSR, 32'h8000_0000, 1'b0));
      instr_queue.push_back(shimm_instr(5'd0, sobs_pkg::SHIFT_ASR, 32'h8000_0000, 1'b0));
      instr_queue.push_back(shimm_instr(5'd0, sobs_pkg::SHIFT_ASR, 32'h7FFF_FFFF, 1'b1));
      instr_queue.push_back(shimm_instr(5'd31, sobs_pkg::SHIFT_ASR, 32'h8000_0000, 1'b0));
      instr_queue.push_back(shimm_instr(5'd0, sobs_pkg::SHIFT_ROR, 32'h0000_0001, 1'b1));
      instr_queue.push_back(shimm_instr(5'd5, sobs_pkg::SHIFT_ROR, 32'h1234_5678, 1'b0));
      instr_queue.push_back(shreg_instr(sobs_pkg::SHIFT_LSL, 4'h3, 32'hDEAD_BEEF, 8'd0,
                                        1'b1));
      instr_queue.push_back(shreg_instr(sobs_pkg::SHIFT_LSL, 4'h3, 32'h0000_0001, 8'd32,
                                        1'b0));
      instr_queue.push_back(shreg_instr(sobs_pkg::SHIFT_LSL, 4'h3, 32'hFFFF_FFFF, 8'd33,
                                        1'b1));
      instr_queue.push_back(shreg_instr(sobs_pkg::SHIFT_LSR, 4'h3, 32'h8000_0000, 8'd32,
                                        1'b0));
      instr_queue.push_back(shreg_instr(sobs_pkg::SHIFT_LSR, 4'h3, 32'hFFFF_FFFF, 8'd255,
                                        1'b1));
      instr_queue.push_back(shreg_instr(sobs_pkg::SHIFT_ASR, 4'h3, 32'h8000_0000, 8'd32,
                                        1'b0));
      instr_queue.push_back(shreg_instr(sobs_pkg::SHIFT_ASR, 4'h3, 32'h7FFF_FFFF, 8'd200,
                                        1'b1));
      instr_queue.push_back(shreg_instr(sobs_pkg::SHIFT_ROR, 4'h3, 32'h8000_0001, 8'd32,
                                        1'b0));
      instr_queue.push_back(shreg_instr(sobs_pkg::SHIFT_ROR, 4'h3, 32'h8000_0003, 8'd64,
                                        1'b0));
      instr_queue.push_back(shreg_instr(sobs_pkg::SHIFT_ROR, 4'h3, 32'h0000_0003, 8'd33,
                                        1'b0));
      // PC as Rm with register shift: +4 wraps past zero
      instr_queue.push_back(shreg_instr(sobs_pkg::SHIFT_LSL, sobs_pkg::PC_INDEX,
                                        32'hFFFF_FFFE, 8'd30, 1'b0));
      // bit 7 set alongside register shift select
      item = shreg_instr(sobs_pkg::SHIFT_LSR, 4'h1, 32'hF000_000F, 8'd4, 1'b1);
      item.operand_field[7] = 1'b1;
      instr_queue.push_back(item);

      repeat (RANDOM_INSTRS) begin
         item.operand_field = 12'($urandom_range(4095));
         item.is_immediate  = 1'($urandom_range(1));
         case ($urandom_range(9))
            0:       item.rm_value = 32'h0000_0000;
            1:       item.rm_value = 32'hFFFF_FFFF;
            2:       item.rm_value = 32'h8000_0000;
            3:       item.rm_value = 32'hFFFF_FFF8 + 32'($urandom_range(7));
            default: item.rm_value = $urandom;
         endcase
         case ($urandom_range(3))
            0:       item.shift_register_byte = 8'($urandom_range(255));
            1:       item.shift_register_byte = 8'($urandom_range(34));
            2:       item.shift_register_byte = 8'(32 * $urandom_range(7));
            default: item.shift_register_byte = 8'(32 * $urandom_range(7) + $urandom_range(1));
         endcase
         item.carry_in = 1'($urandom_range(1));
         instr_queue.push_back(item);
      end

      while (reset || instr_queue.size() > 0 || req_if.valid) @(posedge clock);
      while (expected_operands.size() > 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && expected_operands.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
